// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and ignored during reset.
`define TWV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trapped water check failed");

// Next-cycle implication, sampled on the rising clock edge and ignored during reset.
`define TWV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trapped water check failed");

`endif

// ===== hdl/twv_pkg.sv =====
`timescale 1ns / 1ps

package twv_pkg;

    localparam int BAR_IN_W = 16;
    localparam int TOTAL_W  = 26;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } twv_mem_ctl_t;

endpackage

// ===== hdl/twv_store.sv =====
`timescale 1ns / 1ps

module twv_store import twv_pkg::*; #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16
) (
    input  logic                       clk,
    input  twv_mem_ctl_t               mem_ctl,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [DATA_W-1:0]          wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [DATA_W-1:0]          rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/twv_ctrl.sv =====
`timescale 1ns / 1ps

module twv_ctrl import twv_pkg::*; #(
    parameter int MAX_BARS    = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [BAR_IN_W-1:0]                 bar_height,
    input  logic                                last_bar,
    output logic                                result_valid,
    output logic [TOTAL_W-1:0]                  water_total,
    output logic                                overflow,
    output twv_mem_ctl_t                        mem_ctl,
    output logic [$clog2(MAX_BARS)-1:0]         wr_addr,
    output logic [((HEIGHT_BITS < BAR_IN_W) ? HEIGHT_BITS : BAR_IN_W)-1:0] wr_data,
    output logic [$clog2(MAX_BARS)-1:0]         rd_addr,
    input  logic [((HEIGHT_BITS < BAR_IN_W) ? HEIGHT_BITS : BAR_IN_W)-1:0] rd_data
);

    localparam int ADDR_W = $clog2(MAX_BARS);
    localparam int CNT_W  = $clog2(MAX_BARS + 1);
    localparam int H_W    = (HEIGHT_BITS < BAR_IN_W) ? HEIGHT_BITS : BAR_IN_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BARS);

    typedef enum logic [2:0] {
        S_LOAD,
        S_FWD,
        S_FWD_END,
        S_BWD,
        S_BWD_END
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [H_W-1:0]     tall_h_reg, tall_h_next;
    logic [ADDR_W-1:0]  tall_pos_reg, tall_pos_next;
    logic [H_W-1:0]     max_reg, max_next;
    logic [TOTAL_W-1:0] sum_reg, sum_next;
    logic               ovf_reg, ovf_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               res_valid_reg, res_valid_next;
    logic [TOTAL_W-1:0] res_total_reg, res_total_next;
    logic               res_ovf_reg, res_ovf_next;

    logic [H_W-1:0]     h_in;
    logic               accept;
    logic [CNT_W-1:0]   ptr_dec;
    logic [CNT_W-1:0]   bwd_stop;
    logic [H_W-1:0]     diff;
    logic [TOTAL_W:0]   sum_ext;

    assign h_in     = bar_height[H_W-1:0];
    assign accept   = start && (state_reg == S_LOAD);
    assign ptr_dec  = ptr_reg - CNT_W'(1);
    assign bwd_stop = CNT_W'(tall_pos_reg) + CNT_W'(1);
    assign diff     = max_reg - rd_data;
    assign sum_ext  = {1'b0, sum_reg} + {{(TOTAL_W + 1 - H_W){1'b0}}, diff};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        tall_h_next    = tall_h_reg;
        tall_pos_next  = tall_pos_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        rd_valid_next  = 1'b0;
        res_valid_next = 1'b0;
        res_total_next = res_total_reg;
        res_ovf_next   = res_ovf_reg;
        mem_ctl        = '{wr_en: 1'b0, rd_en: 1'b0};
        wr_addr        = count_reg[ADDR_W-1:0];
        wr_data        = h_in;
        rd_addr        = ptr_reg[ADDR_W-1:0];

        if (rd_valid_reg)
        begin
            if (max_reg > rd_data)
            begin
                sum_next = sum_ext[TOTAL_W] ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
            end
            else
            begin
                max_next = rd_data;
            end
        end

        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_FULL)
                    begin
                        mem_ctl.wr_en = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                        if (h_in > tall_h_reg)
                        begin
                            tall_h_next   = h_in;
                            tall_pos_next = count_reg[ADDR_W-1:0];
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_bar)
                    begin
                        state_next = S_FWD;
                        ptr_next   = '0;
                        max_next   = '0;
                    end
                end
            end
            S_FWD:
            begin
                if (ptr_reg < CNT_W'(tall_pos_reg))
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_valid_next = 1'b1;
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_FWD_END;
                end
            end
            S_FWD_END:
            begin
                max_next   = '0;
                ptr_next   = count_reg;
                state_next = S_BWD;
            end
            S_BWD:
            begin
                rd_addr = ptr_dec[ADDR_W-1:0];
                if (ptr_reg > bwd_stop)
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_valid_next = 1'b1;
                    ptr_next      = ptr_dec;
                end
                else
                begin
                    state_next = S_BWD_END;
                end
            end
            S_BWD_END:
            begin
                res_valid_next = 1'b1;
                res_total_next = sum_reg;
                res_ovf_next   = ovf_reg;
                count_next     = '0;
                ptr_next       = '0;
                tall_h_next    = '0;
                tall_pos_next  = '0;
                max_next       = '0;
                sum_next       = '0;
                ovf_next       = 1'b0;
                state_next     = S_LOAD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ptr_reg       <= '0;
            tall_h_reg    <= '0;
            tall_pos_reg  <= '0;
            max_reg       <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            rd_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            res_total_reg <= '0;
            res_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            tall_h_reg    <= tall_h_next;
            tall_pos_reg  <= tall_pos_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            rd_valid_reg  <= rd_valid_next;
            res_valid_reg <= res_valid_next;
            res_total_reg <= res_total_next;
            res_ovf_reg   <= res_ovf_next;
        end
    end

    assign busy         = (state_reg != S_LOAD);
    assign result_valid = res_valid_reg;
    assign water_total  = res_total_reg;
    assign overflow     = res_ovf_reg;

endmodule

// ===== hdl/trapped_water_volume_core.sv =====
`timescale 1ns / 1ps

// Channel   Beat marker            Ports
// -------   --------------------   ------------------------
// input     start high, busy low   bar_height, last_bar
// result    result_valid high      water_total, overflow
//
// A bar beat is taken when start is high and busy low; busy stays low while loading.
// After the final bar, the scan reads every stored bar except the tallest, one read
// a cycle, while busy stays high.
// The result beat appears in the first cycle after the scan, when busy has dropped.
// Reset is asynchronous and active low and clears all control state; no memory sweep.
// The receiver cannot stall, so each result is shown for exactly one cycle.

module trapped_water_volume_core import twv_pkg::*; #(
    parameter int MAX_BARS    = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [BAR_IN_W-1:0] bar_height,
    input  logic                last_bar,
    output logic                result_valid,
    output logic [TOTAL_W-1:0]  water_total,
    output logic                overflow
);

    localparam int ADDR_W = $clog2(MAX_BARS);
    localparam int H_W    = (HEIGHT_BITS < BAR_IN_W) ? HEIGHT_BITS : BAR_IN_W;

    twv_mem_ctl_t      mem_ctl;
    logic [ADDR_W-1:0] wr_addr;
    logic [H_W-1:0]    wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [H_W-1:0]    rd_data;

    twv_ctrl #(
        .MAX_BARS    (MAX_BARS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .bar_height   (bar_height),
        .last_bar     (last_bar),
        .result_valid (result_valid),
        .water_total  (water_total),
        .overflow     (overflow),
        .mem_ctl      (mem_ctl),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    twv_store #(
        .DEPTH  (MAX_BARS),
        .DATA_W (H_W)
    ) u_store (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ===== hdl/twv_checker.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module twv_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_bar,
    input logic result_valid
);

    // A result beat only follows a scan, so the block was busy the cycle before.
    `TWV_ASSERT_NOW(a_result_after_scan, result_valid, $past(busy))

    // Two result beats never come back to back.
    `TWV_ASSERT_NEXT(a_result_single, result_valid, !result_valid)

    // Accepting the final bar starts the scan.
    `TWV_ASSERT_NEXT(a_last_starts_scan, start && !busy && last_bar, busy)

    // While loading, no result can show up in the next cycle.
    `TWV_ASSERT_NEXT(a_no_result_from_load, !busy, !result_valid)

endmodule

bind trapped_water_volume_core twv_checker u_twv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .last_bar     (last_bar),
    .result_valid (result_valid)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import twv_pkg::*;

    localparam int MAX_BARS = 1024;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DIR_N = 21;
    localparam int PHASE_BARS = 200;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               ovf;
    } water_res_t;

    typedef struct packed {
        logic [BAR_IN_W-1:0] h;
        logic                last;
        bit                  pinned;
        logic [TOTAL_W-1:0]  total;
        logic                ovf;
    } bar_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [BAR_IN_W-1:0] bar_height;
    logic                last_bar;
    logic                result_valid;
    logic [TOTAL_W-1:0]  water_total;
    logic                overflow;

    water_res_t expected_totals[$];
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned idle_pct;

    logic [BAR_IN_W-1:0] profile_bars [MAX_BARS];
    int unsigned profile_len;
    logic [BAR_IN_W-1:0] peak_height;
    int unsigned peak_pos;
    bit profile_dropped;

    bar_row_t bar_table [DIR_N] = '{
        '{16'h0000, 1'b1, 1'b1, 26'd0, 1'b0},
        '{16'hFFFF, 1'b1, 1'b1, 26'd0, 1'b0},
        '{16'hFFFF, 1'b0, 1'b0, 26'd0, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 26'd0, 1'b0},
        '{16'hFFFF, 1'b1, 1'b1, 26'd65535, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 26'd0, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 26'd0, 1'b0},
        '{16'h0000, 1'b1, 1'b1, 26'd0, 1'b0},
        '{16'h0005, 1'b0, 1'b0, 26'd0, 1'b0},
        '{16'h0002, 1'b0, 1'b0, 26'd0, 1'b0},
        '{16'h0005, 1'b0, 1'b0, 26'd0, 1'b0},
        '{16'h0001, 1'b0, 1'b0, 26'd0, 1'b0},
        '{16'h0005, 1'b1, 1'b0, 26'd0, 1'b0},
        '{16'h0001, 1'b0, 1'b0, 26'd0, 1'b0},
        '{16'hAAAA, 1'b0, 1'b0, 26'd0, 1'b0},
        '{16'h5555, 1'b0, 1'b0, 26'd0, 1'b0},
        '{16'hFFFF, 1'b0, 1'b0, 26'd0, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 26'd0, 1'b0},
        '{16'h0007, 1'b1, 1'b0, 26'd0, 1'b0},
        '{16'h0002, 1'b0, 1'b0, 26'd0, 1'b0},
        '{16'h0003, 1'b1, 1'b0, 26'd0, 1'b0}
    };

    trapped_water_volume_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .bar_height   (bar_height),
        .last_bar     (last_bar),
        .result_valid (result_valid),
        .water_total  (water_total),
        .overflow     (overflow)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Stores one bar and, on the final bar, returns the water held by the profile.
    function automatic bit absorb_bar(input logic [BAR_IN_W-1:0] h, input logic last,
                                      output water_res_t res);
        logic [BAR_IN_W-1:0] level;
        logic [BAR_IN_W-1:0] bar;
        longint unsigned acc;
        int unsigned idx;
        if (profile_len < MAX_BARS)
        begin
            if (h > peak_height)
            begin
                peak_height = h;
                peak_pos = profile_len;
            end
            profile_bars[profile_len] = h;
            profile_len++;
        end
        else
        begin
            profile_dropped = 1'b1;
        end
        res = '0;
        if (!last)
            return 1'b0;
        // Left of the peak is scanned upward, right of it downward from the end.
        acc = 0;
        level = '0;
        for (int unsigned k = 0; k < profile_len; k++)
        begin
            if (k == peak_pos)
                level = '0;
            idx = (k < peak_pos) ? k : profile_len - 1 - (k - peak_pos);
            if (idx != peak_pos)
            begin
                bar = profile_bars[idx];
                if (level > bar)
                begin
                    acc += level - bar;
                    if (acc > TOTAL_MAX)
                        acc = TOTAL_MAX;
                end
                else
                begin
                    level = bar;
                end
            end
        end
        res.total = acc[TOTAL_W-1:0];
        res.ovf = profile_dropped;
        profile_len = 0;
        peak_height = '0;
        peak_pos = 0;
        profile_dropped = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_bar(input logic [BAR_IN_W-1:0] h, input logic last,
                            input bit pinned, input water_res_t pinned_res);
        water_res_t res;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        bar_height <= h;
        last_bar <= last;
        do
            @(posedge clk);
        while (busy);
        if (absorb_bar(h, last, res))
            expected_totals.push_back(pinned ? pinned_res : res);
    endtask

    function automatic logic [BAR_IN_W-1:0] pick_height(input int unsigned mode);
        case (mode)
            0: return BAR_IN_W'($urandom_range(0, 65535));
            1: return BAR_IN_W'($urandom_range(0, 15));
            2: return ($urandom_range(1) != 0) ? '1 : '0;
            default: return BAR_IN_W'($urandom_range(0, 300));
        endcase
    endfunction

    task automatic send_profile(input int unsigned len);
        int unsigned mode;
        mode = $urandom_range(3);
        for (int unsigned i = 0; i < len; i++)
            send_bar(pick_height(mode), i == len - 1, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_totals.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual total %0d ovf %0d",
                         $time, water_total, overflow);
                error_count++;
            end
            else
            begin
                if (water_total !== expected_totals[0].total)
                begin
                    $display("%0t: water_total expected %0d actual %0d",
                             $time, expected_totals[0].total, water_total);
                    error_count++;
                end
                if (overflow !== expected_totals[0].ovf)
                begin
                    $display("%0t: overflow expected %0d actual %0d",
                             $time, expected_totals[0].ovf, overflow);
                    error_count++;
                end
                void'(expected_totals.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned phase_idle [4] = '{0, 66, 0, 37};
        start = 1'b0;
        bar_height = '0;
        last_bar = 1'b0;
        rst_n = 1'b0;
        error_count = 0;
        cycle_count = 0;
        idle_pct = 0;
        profile_len = 0;
        peak_height = '0;
        peak_pos = 0;
        profile_dropped = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (bar_table[i])
            send_bar(bar_table[i].h, bar_table[i].last, bar_table[i].pinned,
                     '{bar_table[i].total, bar_table[i].ovf});

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            // The last phase fills the store and drops a few bars, the final one too.
            if (p == 3)
                send_profile(MAX_BARS + 3);
            sent = 0;
            while (sent < PHASE_BARS)
            begin
                automatic int unsigned len = ($urandom_range(99) < 85) ?
                    $urandom_range(1, 16) : $urandom_range(17, 64);
                send_profile(len);
                sent += len;
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (expected_totals.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
